### src/bth_pkg.sv
`timescale 1ns / 1ps

package bth_pkg;

   // Table depth is a power of two so the home slot is a plain bit field.
   localparam int unsigned SLOT_BITS    = 10;
   localparam int unsigned TABLE_DEPTH  = 1 << SLOT_BITS;
   localparam int unsigned HASH_SHIFT   = 4;
   localparam int unsigned ADDRESS_BITS = 32;
   localparam int unsigned SIZE_BITS    = 32;
   localparam int unsigned SEQ_BITS     = 32;

   typedef logic [SLOT_BITS-1:0]    slot_type;
   typedef logic [ADDRESS_BITS-1:0] addr_type;
   typedef logic [SIZE_BITS-1:0]    size_type;
   typedef logic [SEQ_BITS-1:0]     seq_type;

   typedef enum logic {
      KIND_RECORD  = 1'b0,
      KIND_RELEASE = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_NULL_ALLOC   = 3'd1,
      ST_FULL         = 3'd2,
      ST_NOT_FOUND    = 3'd3,
      ST_NULL_RELEASE = 3'd4
   } status_type;

   typedef struct packed {
      kind_type kind;
      addr_type address;
      size_type size;
   } req_type;

   typedef struct packed {
      status_type status;
      slot_type   slot;
      seq_type    sequence_res;
      size_type   block_size;
   } rsp_type;

   typedef enum logic [1:0] {
      FSM_CLEAR = 2'd0,
      FSM_IDLE  = 2'd1,
      FSM_PROBE = 2'd2
   } state_type;

   typedef struct packed {
      logic clear;   // write zero to the slot under the sweep index
      logic accept;  // latch request, start read at home slot
      logic probe;   // compare one slot, advance
      logic commit;  // match found: update slot, send response
      logic fail;    // whole table probed, no match
   } ctl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic addr_null;
      logic match;
      logic exhausted;
   } dp_status_type;

endpackage

### src/bth_ctrl.sv
`timescale 1ns / 1ps

module bth_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  bth_pkg::dp_status_type dp_status,
   output logic                   busy,
   output bth_pkg::ctl_cmd_type   cmd
);

   bth_pkg::state_type state_ff;
   bth_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bth_pkg::FSM_CLEAR: begin
            if (dp_status.clr_last) state_in = bth_pkg::FSM_IDLE;
         end
         bth_pkg::FSM_IDLE: begin
            if (start && !dp_status.addr_null) state_in = bth_pkg::FSM_PROBE;
         end
         bth_pkg::FSM_PROBE: begin
            if (dp_status.match || dp_status.exhausted) state_in = bth_pkg::FSM_IDLE;
         end
         default: state_in = bth_pkg::FSM_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         bth_pkg::FSM_CLEAR: begin
            cmd.clear = 1'b1;
         end
         bth_pkg::FSM_IDLE: begin
            busy       = 1'b0;
            cmd.accept = start;
         end
         bth_pkg::FSM_PROBE: begin
            cmd.probe  = 1'b1;
            cmd.commit = dp_status.match;
            cmd.fail   = !dp_status.match && dp_status.exhausted;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bth_pkg::FSM_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### src/bth_datapath.sv
`timescale 1ns / 1ps

module bth_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  bth_pkg::req_type       req_item,
   input  bth_pkg::ctl_cmd_type   cmd,
   output bth_pkg::dp_status_type dp_status,
   output logic                   rsp_strobe,
   output bth_pkg::rsp_type       rsp_item
);

   bth_pkg::addr_type addr_mem [bth_pkg::TABLE_DEPTH];
   bth_pkg::size_type size_mem [bth_pkg::TABLE_DEPTH];
   bth_pkg::seq_type  seq_mem  [bth_pkg::TABLE_DEPTH];

   bth_pkg::req_type  item_ff, item_in;
   bth_pkg::slot_type idx_ff, idx_in;
   bth_pkg::slot_type count_ff, count_in;
   bth_pkg::seq_type  next_seq_ff, next_seq_in;
   bth_pkg::addr_type rd_addr_ff;
   bth_pkg::size_type rd_size_ff;
   bth_pkg::seq_type  rd_seq_ff;
   logic              rsp_strobe_ff, rsp_strobe_in;
   bth_pkg::rsp_type  rsp_item_ff, rsp_item_in;

   bth_pkg::addr_type shifted;
   bth_pkg::slot_type home;
   bth_pkg::slot_type idx_inc;
   bth_pkg::slot_type rd_index;
   bth_pkg::addr_type want;
   logic              is_release;

   assign shifted    = req_item.address >> bth_pkg::HASH_SHIFT;
   assign home       = shifted[bth_pkg::SLOT_BITS-1:0];
   assign idx_inc    = idx_ff + bth_pkg::slot_type'(1);
   assign rd_index   = cmd.accept ? home : idx_inc;
   assign is_release = (item_ff.kind == bth_pkg::KIND_RELEASE);
   // record looks for an empty slot, release for its own address
   assign want       = is_release ? item_ff.address : '0;

   assign dp_status.clr_last  = (idx_ff == bth_pkg::slot_type'(bth_pkg::TABLE_DEPTH - 1));
   assign dp_status.addr_null = (req_item.address == '0);
   assign dp_status.match     = (rd_addr_ff == want);
   assign dp_status.exhausted = (count_ff == bth_pkg::slot_type'(bth_pkg::TABLE_DEPTH - 1));

   always_comb begin
      item_in       = item_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      next_seq_in   = next_seq_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;

      if (cmd.clear) begin
         idx_in = idx_inc;
      end

      if (cmd.accept) begin
         item_in  = req_item;
         idx_in   = home;
         count_in = '0;
         if (dp_status.addr_null) begin
            rsp_strobe_in            = 1'b1;
            rsp_item_in.status       = (req_item.kind == bth_pkg::KIND_RELEASE) ?
                                       bth_pkg::ST_NULL_RELEASE : bth_pkg::ST_NULL_ALLOC;
            rsp_item_in.slot         = '0;
            rsp_item_in.sequence_res = '0;
            rsp_item_in.block_size   = req_item.size;
         end
      end

      if (cmd.probe) begin
         idx_in   = idx_inc;
         count_in = count_ff + bth_pkg::slot_type'(1);
      end

      if (cmd.commit) begin
         rsp_strobe_in            = 1'b1;
         rsp_item_in.status       = bth_pkg::ST_OK;
         rsp_item_in.slot         = idx_ff;
         rsp_item_in.sequence_res = is_release ? rd_seq_ff : next_seq_ff;
         rsp_item_in.block_size   = is_release ? rd_size_ff : item_ff.size;
         if (!is_release) next_seq_in = next_seq_ff + bth_pkg::seq_type'(1);
      end

      if (cmd.fail) begin
         rsp_strobe_in            = 1'b1;
         rsp_item_in.status       = is_release ? bth_pkg::ST_NOT_FOUND : bth_pkg::ST_FULL;
         rsp_item_in.slot         = '0;
         rsp_item_in.sequence_res = '0;
         rsp_item_in.block_size   = item_ff.size;
      end
   end

   // table storage: one write port, one registered read port per array
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         addr_mem[idx_ff] <= '0;
      end else if (cmd.commit) begin
         addr_mem[idx_ff] <= is_release ? '0 : item_ff.address;
      end
      if (cmd.commit) begin
         size_mem[idx_ff] <= is_release ? '0 : item_ff.size;
         if (!is_release) seq_mem[idx_ff] <= next_seq_ff;
      end
      rd_addr_ff <= addr_mem[rd_index];
      rd_size_ff <= size_mem[rd_index];
      rd_seq_ff  <= seq_mem[rd_index];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         next_seq_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         next_seq_ff   <= next_seq_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      count_ff    <= count_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

### src/block_tracking_hash_table.sv
`timescale 1ns / 1ps

// Channel    Ports                       Handshake
// request    start, busy, req_item       taken at clock edge with start=1, busy=0
// response   rsp_strobe, rsp_item        one cycle per request, strobe marks it
//
// A request with a null address is answered in the cycle after it is
// taken. Otherwise the table is probed one slot per cycle from the home
// slot through the single read port of the address memory, examining 1 to
// 1024 slots. The response appears the cycle after the last probe, and the
// next request may be taken in that same cycle.
// After reset all 1024 slots of the address table are swept to empty, one slot
// per cycle, with busy high until the sweep ends. The response side cannot stall.

module block_tracking_hash_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bth_pkg::req_type req_item,
   output logic             rsp_strobe,
   output bth_pkg::rsp_type rsp_item
);

   bth_pkg::ctl_cmd_type   cmd;
   bth_pkg::dp_status_type dp_status;

   // sequencer: sweep, idle, probe
   bth_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .dp_status (dp_status),
      .busy      (busy),
      .cmd       (cmd)
   );

   // tables, probe index, sequence counter, response register
   bth_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .dp_status  (dp_status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

`ifndef SYNTH
   // null address never probes: answer comes on the next cycle
   a_null_fast: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.address == '0) |=> rsp_strobe)
      else $error("null request not answered next cycle");

   // an accepted request either starts probing or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted request dropped");

   // a response always coincides with return to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response while busy");

   // failed requests carry zero slot and sequence
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status != bth_pkg::ST_OK) |->
      (rsp_item.slot == '0 && rsp_item.sequence_res == '0))
      else $error("failed response with nonzero slot or sequence");
`endif

endmodule
